// ----- rtl/mf_pkg.sv -----
// mf_pkg: widths, constants and types shared by the modular factorial block
// no dependencies; imported by the channel interfaces and all rtl modules
package mf_pkg;

    localparam int K_WIDTH   = 16;
    localparam int MOD_WIDTH = 32;

    // apb data is 32 bits unless the modulus needs 64
    localparam int APB_DW = (MOD_WIDTH > 32) ? 64 : 32;
    // one register: byte stride 4 (or 8), one extra index bit above the stride
    localparam int APB_AW = (MOD_WIDTH > 32) ? 4 : 3;

    // counts the bits of the multiplier operand, K_WIDTH-1 down to 0
    localparam int CNT_W = $clog2(K_WIDTH);

    localparam logic [MOD_WIDTH-1:0] MOD_RESET = MOD_WIDTH'(64'd1000000007);

    // operands handed to the modular multiplier with its start strobe
    typedef struct packed {
        logic [MOD_WIDTH-1:0] a;
        logic [K_WIDTH-1:0]   b;
        logic [MOD_WIDTH-1:0] m;
    } t_mm_req;

endpackage

// ----- rtl/mf_if.sv -----
// mf_if: valid/ready channel interfaces for the request (k) and result sides
// depends on mf_pkg for the field widths
interface mf_k_if import mf_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [K_WIDTH-1:0] k;

    modport source (output valid, output k, input ready);
    modport sink   (input valid, input k, output ready);
endinterface

interface mf_res_if import mf_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [MOD_WIDTH-1:0] result;

    modport source (output valid, output result, input ready);
    modport sink   (input valid, input result, output ready);
endinterface

// ----- rtl/mf_modmul.sv -----
// mf_modmul: iterative (a * b) mod m, msb-first double-and-add over b
// one shared modular adder, used for a doubling step and an add step per bit of b; depends on mf_pkg
module mf_modmul import mf_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  t_mm_req              i_req,
    output logic                 o_done,
    output logic [MOD_WIDTH-1:0] o_product
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_DBL,
        S_ADD,
        S_DONE
    } t_state;

    t_state               r_state;
    logic [MOD_WIDTH-1:0] r_acc;
    logic [MOD_WIDTH-1:0] r_a;
    logic [K_WIDTH-1:0]   r_b;
    logic [MOD_WIDTH:0]   r_m;     // modulus, zero taken as 2^MOD_WIDTH
    logic [CNT_W-1:0]     r_cnt;

    logic [MOD_WIDTH-1:0] add_rhs;
    logic [MOD_WIDTH-1:0] add_sum;

    // (x + y) mod m for x, y < m
    function automatic logic [MOD_WIDTH-1:0] add_mod(
        input logic [MOD_WIDTH-1:0] x,
        input logic [MOD_WIDTH-1:0] y,
        input logic [MOD_WIDTH:0]   m
    );
        logic [MOD_WIDTH:0] room;
        logic [MOD_WIDTH:0] xe;
        logic [MOD_WIDTH:0] s;
        room = m - {1'b0, y};
        xe   = {1'b0, x};
        if (xe >= room) begin
            s = xe - room;
        end else begin
            s = xe + {1'b0, y};
        end
        return s[MOD_WIDTH-1:0];
    endfunction

    // shared adder: doubling step adds acc, add step adds a when the bit is set
    always_comb begin
        if (r_state == S_DBL) begin
            add_rhs = r_acc;
        end else if (r_b[K_WIDTH-1]) begin
            add_rhs = r_a;
        end else begin
            add_rhs = '0;
        end
        add_sum = add_mod(r_acc, add_rhs, r_m);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_acc   <= '0;
                        r_a     <= i_req.a;
                        r_b     <= i_req.b;
                        r_m     <= (i_req.m == '0) ? {1'b1, {MOD_WIDTH{1'b0}}}
                                                   : {1'b0, i_req.m};
                        r_cnt   <= CNT_W'(K_WIDTH - 1);
                        r_state <= S_DBL;
                    end
                end
                S_DBL: begin
                    r_acc   <= add_sum;
                    r_state <= S_ADD;
                end
                S_ADD: begin
                    r_acc <= add_sum;
                    r_b   <= {r_b[K_WIDTH-2:0], 1'b0};
                    if (r_cnt == '0) begin
                        r_state <= S_DONE;
                    end else begin
                        r_cnt   <= r_cnt - CNT_W'(1);
                        r_state <= S_DBL;
                    end
                end
                S_DONE: begin
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_done    = (r_state == S_DONE);
    assign o_product = r_acc;

endmodule

// ----- rtl/modular_factorial.sv -----
// modular_factorial: k! mod modulus, one modular multiplication per factor 2..k
// one request at a time; each multiplication uses the shared modular adder in
//   mf_modmul twice per bit of the factor; a new request may enter while the
//   previous result waits. reset: modulus 1000000007, idle, no result
module modular_factorial import mf_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    mf_k_if.sink              i_k_ch,
    mf_res_if.source          o_res_ch,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_START,
        S_WAIT,
        S_FIN
    } t_state;

    t_state               r_state;
    logic [MOD_WIDTH-1:0] r_mod;
    logic [MOD_WIDTH-1:0] r_m;      // modulus held for the request in flight
    logic [K_WIDTH-1:0]   r_k;
    logic [K_WIDTH-1:0]   r_i;
    logic [MOD_WIDTH-1:0] r_acc;
    logic                 r_out_valid;
    logic [MOD_WIDTH-1:0] r_result;

    logic                 cfg_wr;
    logic                 cfg_sel;
    logic                 mm_start;
    t_mm_req              mm_req;
    logic                 mm_done;
    logic [MOD_WIDTH-1:0] mm_product;

    assign pready  = 1'b1;
    assign cfg_sel = (paddr[APB_AW-1] == 1'b0);
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign prdata  = cfg_sel ? APB_DW'(r_mod) : '0;

    assign i_k_ch.ready    = (r_state == S_IDLE);
    assign o_res_ch.valid  = r_out_valid;
    assign o_res_ch.result = r_result;

    assign mm_start = (r_state == S_START);
    assign mm_req   = '{a: r_acc, b: r_i, m: r_m};

    mf_modmul u_modmul (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (mm_start),
        .i_req     (mm_req),
        .o_done    (mm_done),
        .o_product (mm_product)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_mod       <= MOD_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (cfg_wr && cfg_sel) begin
                r_mod <= pwdata[MOD_WIDTH-1:0];
            end
            // the finish state reloads the output register itself
            if (r_out_valid && o_res_ch.ready && (r_state != S_FIN)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_k_ch.valid) begin
                        r_k <= i_k_ch.k;
                        r_m <= r_mod;
                        r_i <= K_WIDTH'(2);
                        if (i_k_ch.k <= K_WIDTH'(1)) begin
                            r_acc   <= MOD_WIDTH'(1);
                            r_state <= S_FIN;
                        end else begin
                            // 1 mod m, zero only for a modulus of one
                            r_acc   <= (r_mod == MOD_WIDTH'(1)) ? '0 : MOD_WIDTH'(1);
                            r_state <= S_START;
                        end
                    end
                end
                S_START: begin
                    r_state <= S_WAIT;
                end
                S_WAIT: begin
                    if (mm_done) begin
                        r_acc <= mm_product;
                        if (r_i == r_k) begin
                            r_state <= S_FIN;
                        end else begin
                            r_i     <= r_i + K_WIDTH'(1);
                            r_state <= S_START;
                        end
                    end
                end
                S_FIN: begin
                    if (!r_out_valid || o_res_ch.ready) begin
                        r_out_valid <= 1'b1;
                        r_result    <= r_acc;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // multiplier only reports completion while the sequencer waits on it
    a_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mm_done |-> (r_state == S_WAIT))
        else $error("multiplier done outside wait state");

    // running product stays reduced below a nonzero modulus
    a_acc_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_START) && (r_m != '0)) |-> (r_acc < r_m))
        else $error("running product not reduced");

    // factor index stays within 2..k while multiplying
    a_index_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_START) || (r_state == S_WAIT)) |->
            ((r_i >= K_WIDTH'(2)) && (r_i <= r_k)))
        else $error("factor index out of range");

    // a new result is loaded only when the output register is free or drained
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_FIN) && r_out_valid && !o_res_ch.ready) |=> (r_state == S_FIN))
        else $error("pending result overwritten");

endmodule

// ----- tb/sv/modular_factorial_tb.sv -----
// modular_factorial_tb: checks k! mod modulus for requests sent over the valid/ready channels,
// with the modulus set through the apb port between phases; random gaps on both channel sides
// depends on mf_pkg and the channel interfaces in mf_if, and on the modular_factorial rtl
module modular_factorial_tb import mf_pkg::*; ();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int REG_STRIDE   = APB_DW / 8;
    localparam int REG_MODULUS  = 0;
    localparam int REG_SPARE    = 1;
    localparam logic [APB_AW-1:0] ADDR_MODULUS = APB_AW'(REG_STRIDE * REG_MODULUS);
    localparam logic [APB_AW-1:0] ADDR_SPARE   = APB_AW'(REG_STRIDE * REG_SPARE);
    localparam logic [MOD_WIDTH-1:0] MOD_ALL_ONES  = '1;
    localparam logic [MOD_WIDTH-1:0] MOD_BIG_PRIME = MOD_WIDTH'(64'd4294967291);
    localparam int DRAIN_CYCLES = 8;

    typedef logic [K_WIDTH-1:0] t_k_list[$];

    class factorial_board;
        logic [MOD_WIDTH-1:0] modulus;
        logic [MOD_WIDTH-1:0] pending_results[$];
        int unsigned          mismatches;

        function new();
            modulus     = MOD_RESET;
            mismatches  = 0;
        endfunction

        // exact k! mod modulus; a modulus of zero means wrap at MOD_WIDTH bits
        function logic [MOD_WIDTH-1:0] factorial_mod(input logic [K_WIDTH-1:0] k);
            logic [MOD_WIDTH-1:0]   acc;
            logic [2*MOD_WIDTH-1:0] wide;
            longint unsigned        i;
            if (k <= 1) begin
                return MOD_WIDTH'(1);
            end
            acc = (modulus == MOD_WIDTH'(1)) ? '0 : MOD_WIDTH'(1);
            for (i = 2; i <= k; i++) begin
                wide = {{MOD_WIDTH{1'b0}}, acc} * (2*MOD_WIDTH)'(i);
                if (modulus == '0) begin
                    acc = wide[MOD_WIDTH-1:0];
                end else begin
                    acc = MOD_WIDTH'(wide % {{MOD_WIDTH{1'b0}}, modulus});
                end
            end
            return acc;
        endfunction

        function void note_request(input logic [K_WIDTH-1:0] k);
            pending_results.push_back(factorial_mod(k));
        endfunction

        function void check_result(input logic [MOD_WIDTH-1:0] actual);
            logic [MOD_WIDTH-1:0] want;
            if (pending_results.size() == 0) begin
                $error("result arrived with no request outstanding: result %0d", actual);
                mismatches++;
                return;
            end
            want = pending_results.pop_front();
            if (actual !== want) begin
                $error("result mismatch: expected %0d, actual %0d", want, actual);
                mismatches++;
            end
        endfunction
    endclass

    logic              i_clk;
    logic              i_rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;
    bit                no_idle;

    mf_k_if   k_ch ();
    mf_res_if res_ch ();

    factorial_board board = new();

    modular_factorial DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_k_ch   (k_ch),
        .o_res_ch (res_ch),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    // mostly short gaps, a few long ones
    function int pick_gap();
        int r;
        if (no_idle) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 50) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 40);
    endfunction

    // small k dominate, as every factor up to k costs a full modular multiplication
    function logic [K_WIDTH-1:0] pick_k();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10) begin
            return K_WIDTH'($urandom_range(0, 1));
        end else if (r < 75) begin
            return K_WIDTH'($urandom_range(2, 40));
        end else if (r < 95) begin
            return K_WIDTH'($urandom_range(41, 400));
        end
        return K_WIDTH'($urandom_range(401, 2000));
    endfunction

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic send_k(input logic [K_WIDTH-1:0] k);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            k_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        k_ch.valid <= 1'b1;
        k_ch.k     <= k;
        do begin
            @(posedge i_clk);
        end while (!k_ch.ready);
        board.note_request(k);
        @(negedge i_clk);
    endtask

    task automatic send_each(input t_k_list ks);
        foreach (ks[i]) begin
            send_k(ks[i]);
        end
    endtask

    // apb write, then read the modulus back
    task automatic write_reg(input logic [APB_AW-1:0] addr, input logic [MOD_WIDTH-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= APB_DW'(value);
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        if (addr == ADDR_MODULUS) begin
            board.modulus = value;
        end
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= ADDR_MODULUS;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (prdata[MOD_WIDTH-1:0] !== board.modulus) begin
            $error("modulus readback mismatch: expected %0d, actual %0d",
                   board.modulus, prdata[MOD_WIDTH-1:0]);
            board.mismatches++;
        end
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // block is idle once the last result is in; then a DRAIN_CYCLES wait for margin
    task automatic settle();
        k_ch.valid <= 1'b0;
        while (board.pending_results.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            board.check_result(res_ch.result);
        end
    end

    // result side back-pressure
    initial begin
        int gap;
        res_ch.ready = 1'b0;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            gap = pick_gap();
            if (gap > 0) begin
                res_ch.ready <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            res_ch.ready <= 1'b1;
            repeat ($urandom_range(1, 8)) @(negedge i_clk);
        end
    end

    initial begin
        logic [MOD_WIDTH-1:0] phase_mod[8];
        int                   p;
        int                   n;
        i_rst_n    = 1'b0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        k_ch.valid = 1'b0;
        k_ch.k     = '0;
        no_idle    = 1'b0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset modulus, including the full 16-bit k
        send_each('{0, 1, 2, 3, 12, 13, 20, 16'hFFFF});
        settle();
        // modulus of one: 1 for k below 2, else 0
        write_reg(ADDR_MODULUS, MOD_WIDTH'(1));
        send_each('{0, 1, 2, 7});
        settle();
        // modulus of zero wraps at the full width
        write_reg(ADDR_MODULUS, '0);
        send_each('{0, 1, 2, 33, 34});
        settle();
        write_reg(ADDR_MODULUS, MOD_ALL_ONES);
        send_each('{1, 2, 13, 40});
        settle();
        // k reaching the modulus gives zero
        write_reg(ADDR_MODULUS, MOD_WIDTH'(97));
        send_each('{96, 97, 100});
        settle();
        // write to an unused register index must leave the modulus alone
        write_reg(ADDR_SPARE, MOD_WIDTH'(13));
        send_each('{5});
        settle();

        phase_mod[0] = MOD_WIDTH'($urandom());
        phase_mod[1] = '0;
        phase_mod[2] = MOD_WIDTH'(1);
        phase_mod[3] = MOD_ALL_ONES;
        phase_mod[4] = MOD_WIDTH'($urandom_range(2, 300));
        phase_mod[5] = MOD_WIDTH'($urandom());
        phase_mod[6] = MOD_BIG_PRIME;
        phase_mod[7] = MOD_RESET;
        for (p = 0; p < 8; p++) begin
            write_reg(ADDR_MODULUS, phase_mod[p]);
            no_idle = (p == 2 || p == 5);
            for (n = 0; n < 10; n++) begin
                send_k(pick_k());
            end
            settle();
        end

        if (board.mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    // timeout, long enough for one k of 65535 alone
    initial begin
        #360ms;
        $display("FAILURE");
        $finish;
    end

endmodule
